>>> hdl/lrsb_pkg.sv
// Shared types, codes and constants of the row-segment buffer cache.
package lrsb_pkg;

  localparam int TYPE_W     = 3;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int WB_W       = 6;
  localparam int CYC_W      = 16;
  localparam int SLOT_W     = 2;
  localparam int TIME_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int SLOTS_DEF     = 4;
  localparam int SEG_WORDS_DEF = 32;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ACT    = 3'd0,
    REQ_RD     = 3'd1,
    REQ_WR     = 3'd2,
    REQ_CHK_RD = 3'd3,
    REQ_CHK_WR = 3'd4
  } req_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_ONLY = 3'd0,
    CFG_T_RCD     = 3'd1,
    CFG_T_AL      = 3'd2,
    CFG_T_BURST   = 3'd3,
    CFG_T_CCD     = 3'd4,
    CFG_T_CWD     = 3'd5,
    CFG_T_WR      = 3'd6,
    CFG_T_RP_EFF  = 3'd7
  } cfg_idx_t;

  localparam logic              READ_ONLY_RST = 1'b1;
  localparam logic [TIME_W-1:0] T_RCD_RST     = 8'd14;
  localparam logic [TIME_W-1:0] T_BURST_RST   = 8'd4;
  localparam logic [TIME_W-1:0] T_CCD_RST     = 8'd4;
  localparam logic [TIME_W-1:0] T_CWD_RST     = 8'd10;
  localparam logic [TIME_W-1:0] T_WR_RST      = 8'd15;
  localparam logic [TIME_W-1:0] T_RP_EFF_RST  = 8'd14;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              cached_only;
  } req_t;

  typedef struct packed {
    logic              served;
    logic              to_bank;
    logic [WB_W-1:0]   writebacks;
    logic [CYC_W-1:0]  activate_cycles;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic              read_only;
    logic [TIME_W-1:0] t_rcd;
    logic [TIME_W-1:0] t_burst;
    logic [TIME_W-1:0] t_ccd;
    logic [TIME_W-1:0] t_cwd;
    logic [TIME_W-1:0] t_wr;
    logic [TIME_W-1:0] t_rp_eff;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic row_hit;
    logic seg_hit;
  } cell_stat_t;

endpackage

>>> hdl/lrsb_cell.sv
// One buffer cell of the LRU chain: holds a row, its segment and dirty words.
module lrsb_cell #(
  parameter int SEG_WORDS = lrsb_pkg::SEG_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lrsb_pkg::cell_ctl_t        ctl,
  input  logic [lrsb_pkg::ROW_W-1:0] key_row,
  input  logic [lrsb_pkg::COL_W-1:0] key_seg,
  input  logic [lrsb_pkg::ROW_W-1:0] ld_row,
  input  logic [lrsb_pkg::COL_W-1:0] ld_seg,
  input  logic [SEG_WORDS-1:0]       ld_dirty,
  input  logic                       nb_valid,
  input  logic [lrsb_pkg::ROW_W-1:0] nb_row,
  input  logic [lrsb_pkg::COL_W-1:0] nb_seg,
  input  logic [SEG_WORDS-1:0]       nb_dirty,
  output logic                       valid,
  output logic [lrsb_pkg::ROW_W-1:0] row,
  output logic [lrsb_pkg::COL_W-1:0] seg,
  output logic [SEG_WORDS-1:0]       dirty,
  output lrsb_pkg::cell_stat_t       stat
);
  import lrsb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      row   <= ld_row;
      seg   <= ld_seg;
      dirty <= ld_dirty;
    end else if (ctl.shift) begin
      row   <= nb_row;
      seg   <= nb_seg;
      dirty <= nb_dirty;
    end
  end

  assign stat.row_hit = valid && (row == key_row);
  assign stat.seg_hit = seg == key_seg;

endmodule

>>> hdl/lrsb_act_time.sv
// Activation time unit: base time plus write-back time, saturated.
module lrsb_act_time #(
  parameter int SEG_WORDS = lrsb_pkg::SEG_WORDS_DEF,
  parameter int D_W       = $clog2(SEG_WORDS + 1)
) (
  input  logic                       clk,
  input  logic                       start,
  input  lrsb_pkg::cfg_t             cfg,
  input  logic [D_W-1:0]             d,
  output logic [lrsb_pkg::CYC_W-1:0] cycles
);
  import lrsb_pkg::*;

  localparam int BASE_W = TIME_W + $clog2(SEG_WORDS + 1);
  localparam int FIX_W  = TIME_W + 3;
  localparam int PROD_W = TIME_W + D_W;
  localparam int MAX_BP = (BASE_W > PROD_W) ? BASE_W : PROD_W;
  localparam int MAX_W  = (MAX_BP > CYC_W) ? MAX_BP : CYC_W;
  localparam int SUM_W  = MAX_W + 2;
  localparam logic [SUM_W-1:0] SAT = SUM_W'((1 << CYC_W) - 1);

  logic [TIME_W-1:0] m;
  logic [D_W-1:0]    dm1;
  logic [BASE_W-1:0] base, base_q;
  logic [FIX_W-1:0]  fix, fix_q;
  logic [PROD_W-1:0] prod, prod_q;
  logic              dnz_q;
  logic [SUM_W-1:0]  total;

  assign m    = (cfg.t_burst > cfg.t_ccd) ? cfg.t_burst : cfg.t_ccd;
  assign dm1  = d - D_W'(1);
  assign base = BASE_W'(cfg.t_rcd) + BASE_W'(cfg.t_ccd) * BASE_W'(SEG_WORDS);
  assign fix  = FIX_W'(cfg.t_rcd) + FIX_W'(cfg.t_cwd) + FIX_W'(cfg.t_burst)
              + FIX_W'(cfg.t_wr) + FIX_W'(cfg.t_rp_eff);
  assign prod = PROD_W'(m) * PROD_W'(dm1);

  always_ff @(posedge clk) begin
    if (start) begin
      base_q <= base;
      fix_q  <= fix;
      prod_q <= prod;
      dnz_q  <= d != '0;
    end
  end

  assign total  = SUM_W'(base_q) + (dnz_q ? (SUM_W'(fix_q) + SUM_W'(prod_q)) : '0);
  assign cycles = (total > SAT) ? '1 : total[CYC_W-1:0];

endmodule

>>> hdl/lru_row_segment_buffer_cache.sv
// Top level of the LRU row-segment buffer cache.
//
// Requests enter on req (req_valid / req_stall); one result per request leaves
// on rsp (rsp_valid / rsp_stall). A transaction completes at a rising edge
// with valid high and stall low. Configuration registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
// The block holds one request at a time and takes no new request until the
// result is taken. States ST_QUOT and ST_REM split the column into segment
// and word by a reciprocal multiply, ST_LOOK compares and updates the cell
// chain and counts dirty words, ST_MUL and ST_SUM build the activation time,
// then the result is held in ST_DONE until taken.
// While rsp_stall is high the result holds and req_stall stays high.
// Reset clears every buffer valid bit and loads the register defaults
// (read-only buffers, default DRAM timings); no clearing pass is needed.
module lru_row_segment_buffer_cache #(
  parameter int SLOTS     = lrsb_pkg::SLOTS_DEF,
  parameter int SEG_WORDS = lrsb_pkg::SEG_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  lrsb_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output lrsb_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [lrsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrsb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrsb_pkg::*;

  localparam int POS_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W   = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
  localparam int D_W     = $clog2(SEG_WORDS + 1);
  localparam int RECIP_W = COL_W + 1;
  localparam int QP_W    = 2 * COL_W + 1;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((1 << COL_W) / SEG_WORDS);
  localparam logic [COL_W:0]     SEG_C    = (COL_W + 1)'(SEG_WORDS);
  localparam logic [POS_W-1:0]   LAST_POS = POS_W'(SLOTS - 1);
  localparam logic [D_W+WB_W:0]  WB_MAX   = (D_W + WB_W + 1)'((1 << WB_W) - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_QUOT = 7'b0000010,
    ST_REM  = 7'b0000100,
    ST_LOOK = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_SUM  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;
  req_t   req_q;

  logic [COL_W-1:0] q_est, seg_q;
  logic [IDX_W-1:0] word_idx;
  logic [QP_W-1:0]  quot_prod;
  logic [COL_W:0]   back, rem_est;

  logic             res_served, res_to_bank, res_act;
  logic [POS_W-1:0] res_pos;
  logic [D_W-1:0]   d_q;
  logic [CYC_W-1:0] act_cyc;

  logic [SLOTS-1:0]     c_valid, row_hit, acc_hit, load_vec, shift_vec;
  logic [ROW_W-1:0]     c_row   [SLOTS];
  logic [COL_W-1:0]     c_seg   [SLOTS];
  logic [SEG_WORDS-1:0] c_dirty [SLOTS];
  cell_stat_t           c_stat  [SLOTS];
  cell_ctl_t            c_ctl   [SLOTS];

  logic                 is_act, is_rd, is_wr, is_chk_rd, is_chk_wr;
  logic                 row_any, free_any, acc_any, alloc, evict, access, check, move;
  logic [POS_W-1:0]     row_pos, free_pos, acc_pos, alloc_pos;
  logic [ROW_W-1:0]     ld_row;
  logic [COL_W-1:0]     ld_seg;
  logic [SEG_WORDS-1:0] ld_dirty;
  logic                 served_d, to_bank_d;
  logic [POS_W-1:0]     pos_d;
  logic [D_W-1:0]       d_d;
  logic [D_W+WB_W:0]    d_ext;
  logic [POS_W+1:0]     pos_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_only <= READ_ONLY_RST;
      cfg.t_rcd     <= T_RCD_RST;
      cfg.t_burst   <= T_BURST_RST;
      cfg.t_ccd     <= T_CCD_RST;
      cfg.t_cwd     <= T_CWD_RST;
      cfg.t_wr      <= T_WR_RST;
      cfg.t_rp_eff  <= T_RP_EFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_READ_ONLY: cfg.read_only <= cfg_data[0];
        CFG_T_RCD:     cfg.t_rcd     <= cfg_data;
        CFG_T_AL:      ; // additive latency cancels out of the activation time
        CFG_T_BURST:   cfg.t_burst   <= cfg_data;
        CFG_T_CCD:     cfg.t_ccd     <= cfg_data;
        CFG_T_CWD:     cfg.t_cwd     <= cfg_data;
        CFG_T_WR:      cfg.t_wr      <= cfg_data;
        CFG_T_RP_EFF:  cfg.t_rp_eff  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_QUOT;
      ST_QUOT: state_next = ST_REM;
      ST_REM:  state_next = ST_LOOK;
      ST_LOOK: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: if (!rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = state != ST_IDLE;
  assign rsp_valid = state == ST_DONE;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req_q <= req;
    end
  end

  // segment number and word offset of the column
  assign quot_prod = QP_W'(req_q.col) * QP_W'(RECIP);
  assign back      = (COL_W + 1)'(q_est * SEG_WORDS);
  assign rem_est   = {1'b0, req_q.col} - back;

  always_ff @(posedge clk) begin
    if (state == ST_QUOT) begin
      q_est <= quot_prod[COL_W +: COL_W];
    end
    if (state == ST_REM) begin
      if (rem_est >= SEG_C) begin
        seg_q    <= q_est + COL_W'(1);
        word_idx <= IDX_W'(rem_est - SEG_C);
      end else begin
        seg_q    <= q_est;
        word_idx <= IDX_W'(rem_est);
      end
    end
  end

  // cell chain
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                 nb_valid;
    logic [ROW_W-1:0]     nb_row;
    logic [COL_W-1:0]     nb_seg;
    logic [SEG_WORDS-1:0] nb_dirty;

    if (i == 0) begin : g_head
      assign nb_valid = 1'b0;
      assign nb_row   = '0;
      assign nb_seg   = '0;
      assign nb_dirty = '0;
    end else begin : g_link
      assign nb_valid = c_valid[i-1];
      assign nb_row   = c_row[i-1];
      assign nb_seg   = c_seg[i-1];
      assign nb_dirty = c_dirty[i-1];
    end

    lrsb_cell #(
      .SEG_WORDS (SEG_WORDS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (c_ctl[i]),
      .key_row  (req_q.row),
      .key_seg  (seg_q),
      .ld_row   (ld_row),
      .ld_seg   (ld_seg),
      .ld_dirty (ld_dirty),
      .nb_valid (nb_valid),
      .nb_row   (nb_row),
      .nb_seg   (nb_seg),
      .nb_dirty (nb_dirty),
      .valid    (c_valid[i]),
      .row      (c_row[i]),
      .seg      (c_seg[i]),
      .dirty    (c_dirty[i]),
      .stat     (c_stat[i])
    );

    assign row_hit[i]   = c_stat[i].row_hit;
    assign acc_hit[i]   = c_stat[i].row_hit && c_stat[i].seg_hit;
    assign c_ctl[i].load  = (state == ST_LOOK) &&
                            ((alloc && alloc_pos == POS_W'(i)) || (move && i == 0));
    assign c_ctl[i].shift = move && (i > 0) && (POS_W'(i) <= acc_pos);
    assign load_vec[i]  = c_ctl[i].load;
    assign shift_vec[i] = c_ctl[i].shift;
  end

  // lookup
  always_comb begin
    is_act    = req_q.req_type == REQ_ACT;
    is_rd     = req_q.req_type == REQ_RD;
    is_wr     = req_q.req_type == REQ_WR;
    is_chk_rd = req_q.req_type == REQ_CHK_RD;
    is_chk_wr = req_q.req_type == REQ_CHK_WR;

    row_any  = |row_hit;
    free_any = ~&c_valid;
    acc_any  = |acc_hit;
    row_pos  = '0;
    free_pos = '0;
    acc_pos  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (row_hit[i])  row_pos  = POS_W'(i);
      if (!c_valid[i]) free_pos = POS_W'(i);
      if (acc_hit[i])  acc_pos  = POS_W'(i);
    end

    alloc     = is_act && !row_any;
    evict     = alloc && !free_any;
    alloc_pos = free_any ? free_pos : LAST_POS;
    access    = is_rd || (is_wr && !cfg.read_only);
    check     = is_chk_rd || (is_chk_wr && !cfg.read_only);
    move      = (state == ST_LOOK) && access && acc_any;

    if (alloc) begin
      ld_row   = req_q.row;
      ld_seg   = seg_q;
      ld_dirty = '0;
    end else begin
      ld_row   = c_row[acc_pos];
      ld_seg   = c_seg[acc_pos];
      ld_dirty = c_dirty[acc_pos] | (is_wr ? (SEG_WORDS'(1) << word_idx) : '0);
    end

    served_d  = 1'b0;
    to_bank_d = 1'b0;
    pos_d     = '0;
    if (is_act) begin
      to_bank_d = 1'b1;
      pos_d     = row_any ? row_pos : alloc_pos;
    end else if (is_rd || is_wr) begin
      if (access && acc_any) begin
        served_d = 1'b1;
        pos_d    = acc_pos;
      end else begin
        to_bank_d = 1'b1;
      end
    end else if (is_chk_rd || is_chk_wr) begin
      if (check && acc_any) begin
        served_d = 1'b1;
        pos_d    = acc_pos;
      end else begin
        to_bank_d = !req_q.cached_only;
      end
    end

    d_d = evict ? D_W'($countones(c_dirty[SLOTS-1])) : '0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      res_served  <= served_d;
      res_to_bank <= to_bank_d;
      res_pos     <= pos_d;
      res_act     <= is_act;
      d_q         <= d_d;
    end
  end

  lrsb_act_time #(
    .SEG_WORDS (SEG_WORDS),
    .D_W       (D_W)
  ) u_act_time (
    .clk    (clk),
    .start  (state == ST_MUL),
    .cfg    (cfg),
    .d      (d_q),
    .cycles (act_cyc)
  );

  // result register
  assign d_ext    = (D_W + WB_W + 1)'(d_q);
  assign pos_wide = {2'b00, res_pos};

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      rsp.served          <= res_served;
      rsp.to_bank         <= res_to_bank;
      rsp.writebacks      <= (d_ext > WB_MAX) ? '1 : d_ext[WB_W-1:0];
      rsp.activate_cycles <= res_act ? act_cyc : '0;
      rsp.slot            <= pos_wide[SLOT_W-1:0];
    end
  end

  a_busy_while_result : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a result is pending");

  a_served_excl : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.served && rsp.to_bank))
    else $error("result both served and sent to bank");

  a_single_load : assert property (@(posedge clk) disable iff (rst)
    $onehot0(load_vec))
    else $error("more than one cell loaded");

  a_front_valid : assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && move) |=> c_valid[0])
    else $error("front cell not valid after move");

  a_chain_quiet : assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOOK) |-> (load_vec == '0 && shift_vec == '0))
    else $error("cell chain changed outside lookup");

endmodule
